// ----- rtl/core/ptf_pkg.sv -----
// shared types and constants for the pan/tilt frame to step target unit
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package ptf_pkg;

  localparam int FRAME_LEN      = 10;
  localparam int IDX_W          = 4;
  localparam int DIV_W          = 48;
  localparam int DIV_STEPS      = DIV_W / 2;
  localparam int DIV_CNT_W      = $clog2(DIV_STEPS);
  localparam logic [15:0] TURN_HUND = 16'd36000;
  localparam logic [15:0] HALF_HUND = 16'd18000;

  // register indexes
  localparam logic [2:0] REG_PAN_STEPS  = 3'd0;
  localparam logic [2:0] REG_TILT_STEPS = 3'd1;
  localparam logic [2:0] REG_TILT_MIN   = 3'd2;
  localparam logic [2:0] REG_TILT_MAX   = 3'd3;
  localparam logic [2:0] REG_PULSE_LEN  = 3'd4;
  localparam logic [2:0] REG_END_MARKER = 3'd5;

  // control byte bits
  localparam int CTL_A     = 0;
  localparam int CTL_B     = 1;
  localparam int CTL_PULSE = 2;

  typedef struct packed {
    logic               kind;
    logic [7:0]         rx_byte;
    logic signed [31:0] pan_position;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] pan_target_steps;
    logic [15:0]        tilt_target_steps;
    logic               out_a;
    logic               out_b;
    logic               pulse_out;
    logic               frame_accepted;
    logic               frame_rejected;
  } out_item_t;

  typedef struct packed {
    logic [15:0] pan_steps;
    logic [15:0] tilt_steps;
    logic [15:0] tilt_min;
    logic [15:0] tilt_max;
    logic [15:0] pulse_len;
    logic [7:0]  end_marker;
  } cfg_t;

  // work handed from front to back
  typedef struct packed {
    logic signed [31:0] pos;
    logic               new_pan;
    logic signed [31:0] pan_raw;
    logic [15:0]        tilt_hund;
    logic               level_a;
    logic               level_b;
    logic               pulse;
    logic               accepted;
    logic               rejected;
  } job_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_NORM,
    ST_CUR,
    ST_MOD,
    ST_DIFF,
    ST_TILT,
    ST_DONE
  } back_state_t;

endpackage

`default_nettype wire

// ----- rtl/core/ptf_front.sv -----
// front: frame assembly, target and pulse state, job generation
// depends on ptf_pkg
`timescale 1ns / 1ps
`default_nettype none

module ptf_front import ptf_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire cfg_t     cfg,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire in_item_t in_data,
  input  wire logic     q_full,
  output logic          q_push,
  output job_t          q_job
);

  logic [IDX_W-1:0] byte_index, byte_index_next;
  logic [7:0]       frame_store [FRAME_LEN-1];
  logic [15:0]      tilt_hund, tilt_hund_next;
  logic             level_a, level_a_next;
  logic             level_b, level_b_next;
  logic             pulse_active, pulse_active_next;
  logic [15:0]      pulse_elapsed, pulse_elapsed_next;
  logic             accepted, rejected;
  logic signed [31:0] pan_raw, tilt_raw;
  logic [7:0]       ctl;

  assign in_ready = !q_full;
  assign q_push   = in_valid && in_ready;

  assign pan_raw  = {frame_store[0], frame_store[1], frame_store[2], frame_store[3]};
  assign tilt_raw = {frame_store[4], frame_store[5], frame_store[6], frame_store[7]};
  assign ctl      = frame_store[8];

  // state update for one transaction
  always_comb begin
    byte_index_next    = byte_index;
    tilt_hund_next     = tilt_hund;
    level_a_next       = level_a;
    level_b_next       = level_b;
    pulse_active_next  = pulse_active;
    pulse_elapsed_next = pulse_elapsed;
    accepted           = 1'b0;
    rejected           = 1'b0;
    if (!in_data.kind) begin
      if (byte_index < IDX_W'(FRAME_LEN - 1)) begin
        byte_index_next = byte_index + IDX_W'(1);
      end else begin
        byte_index_next = '0;
        if (in_data.rx_byte == cfg.end_marker) begin
          accepted = 1'b1;
          if (tilt_raw < $signed({16'b0, cfg.tilt_min})) begin
            tilt_hund_next = cfg.tilt_min;
          end else if (tilt_raw > $signed({16'b0, cfg.tilt_max})) begin
            tilt_hund_next = cfg.tilt_max;
          end else begin
            tilt_hund_next = tilt_raw[15:0];
          end
          level_a_next = ctl[CTL_A];
          level_b_next = ctl[CTL_B];
          if (ctl[CTL_PULSE]) begin
            pulse_active_next  = 1'b1;
            pulse_elapsed_next = '0;
          end
        end else begin
          rejected = 1'b1;
        end
      end
    end else if (pulse_elapsed != 16'hFFFF) begin
      pulse_elapsed_next = pulse_elapsed + 16'd1;
    end
    if (pulse_active_next && pulse_elapsed_next > cfg.pulse_len) begin
      pulse_active_next = 1'b0;
    end
  end

  // job contents
  always_comb begin
    q_job.pos       = in_data.pan_position;
    q_job.new_pan   = accepted;
    q_job.pan_raw   = pan_raw;
    q_job.tilt_hund = tilt_hund_next;
    q_job.level_a   = level_a_next;
    q_job.level_b   = level_b_next;
    q_job.pulse     = pulse_active_next;
    q_job.accepted  = accepted;
    q_job.rejected  = rejected;
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index    <= '0;
      tilt_hund     <= 16'd3000;
      level_a       <= 1'b0;
      level_b       <= 1'b0;
      pulse_active  <= 1'b0;
      pulse_elapsed <= '0;
    end else if (q_push) begin
      byte_index    <= byte_index_next;
      tilt_hund     <= tilt_hund_next;
      level_a       <= level_a_next;
      level_b       <= level_b_next;
      pulse_active  <= pulse_active_next;
      pulse_elapsed <= pulse_elapsed_next;
    end
  end

  // frame bytes
  always_ff @(posedge clk) begin
    if (q_push && !in_data.kind && byte_index < IDX_W'(FRAME_LEN - 1)) begin
      frame_store[byte_index] <= in_data.rx_byte;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/ptf_queue.sv -----
// two-entry job queue between front and back
// depends on ptf_pkg
`timescale 1ns / 1ps
`default_nettype none

module ptf_queue import ptf_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire job_t push_job,
  output logic      full,
  input  wire logic pop,
  output logic      not_empty,
  output job_t      head
);

  job_t       mem [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;

  assign full      = count == 2'd2;
  assign not_empty = count != 2'd0;
  assign head      = mem[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      if (push && !pop)      count <= count + 2'd1;
      else if (pop && !push) count <= count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_job;
  end

endmodule

`default_nettype wire

// ----- rtl/core/ptf_divider.sv -----
// unsigned radix-4 restoring divider, two quotient bits per cycle
// depends on ptf_pkg
`timescale 1ns / 1ps
`default_nettype none

module ptf_divider import ptf_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [DIV_W-1:0] dividend,
  input  wire logic [15:0]      divisor,
  output logic                  done,
  output logic [DIV_W-1:0]      quo,
  output logic [15:0]           rem
);

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [15:0]          dvs;
  logic [16:0]          r1, r2, r1s, r2s;
  logic                 ge1, ge2;

  // two shift-subtract steps
  always_comb begin
    r1  = {rem, quo[DIV_W-1]};
    ge1 = r1 >= {1'b0, dvs};
    r1s = ge1 ? r1 - {1'b0, dvs} : r1;
    r2  = {r1s[15:0], quo[DIV_W-2]};
    ge2 = r2 >= {1'b0, dvs};
    r2s = ge2 ? r2 - {1'b0, dvs} : r2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + DIV_CNT_W'(1);
        if (cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      quo <= {quo[DIV_W-3:0], ge1, ge2};
      rem <= r2s[15:0];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/ptf_back.sv -----
// back: step target arithmetic on a shared divider, result register
// depends on ptf_pkg and ptf_divider
`timescale 1ns / 1ps
`default_nettype none

module ptf_back import ptf_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire cfg_t cfg,
  input  wire logic q_valid,
  input  wire job_t q_job,
  output logic      q_pop,
  output logic      out_valid,
  input  wire logic out_ready,
  output out_item_t out_data
);

  back_state_t state, state_next;
  job_t        job;
  logic        issued;
  logic [15:0] pan_t;
  logic signed [16:0] diff;
  logic signed [31:0] pan_res;
  logic [15:0] tilt_res;
  logic [15:0] p_eff, t_eff;
  logic        div_start, div_done;
  logic [DIV_W-1:0] div_dividend, div_quo;
  logic [15:0] div_divisor, div_rem;
  logic [31:0] pos_mag, raw_mag;
  logic [14:0] diff_mag;
  logic signed [17:0] cur, d0, d1, d2;
  logic signed [31:0] step_off;
  logic        is_div, load_out;

  assign p_eff    = (cfg.pan_steps == '0) ? 16'd1 : cfg.pan_steps;
  assign t_eff    = (cfg.tilt_steps == '0) ? 16'd1 : cfg.tilt_steps;
  assign pos_mag  = job.pos[31] ? 32'(-job.pos) : job.pos;
  assign raw_mag  = job.pan_raw[31] ? 32'(-job.pan_raw) : job.pan_raw;
  assign diff_mag = diff[16] ? 15'(-diff) : diff[14:0];

  // shortest-path difference from current position remainder
  always_comb begin
    cur = job.pos[31] ? -$signed({2'b0, div_rem}) : $signed({2'b0, div_rem});
    d0  = $signed({2'b0, pan_t}) - cur;
    d1  = (d0 >= $signed({2'b0, TURN_HUND})) ? d0 - $signed({2'b0, TURN_HUND}) : d0;
    if (d1 > $signed({2'b0, HALF_HUND})) begin
      d2 = d1 - $signed({2'b0, TURN_HUND});
    end else if (d1 < -$signed({2'b0, HALF_HUND})) begin
      d2 = d1 + $signed({2'b0, TURN_HUND});
    end else begin
      d2 = d1;
    end
  end

  assign step_off = diff[16] ? -$signed(div_quo[31:0]) : $signed(div_quo[31:0]);

  // divider operand selection
  always_comb begin
    div_divisor  = TURN_HUND;
    div_dividend = '0;
    unique case (state)
      ST_NORM: div_dividend = {16'b0, raw_mag};
      ST_CUR: begin
        div_dividend = DIV_W'(pos_mag) * DIV_W'(TURN_HUND);
        div_divisor  = p_eff;
      end
      ST_MOD:  div_dividend = div_quo;
      ST_DIFF: div_dividend = DIV_W'({17'b0, diff_mag} * {16'b0, p_eff});
      ST_TILT: div_dividend = DIV_W'({16'b0, job.tilt_hund} * {16'b0, t_eff});
      default: div_dividend = '0;
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (q_valid) state_next = q_job.new_pan ? ST_NORM : ST_CUR;
      ST_NORM: if (div_done) state_next = ST_CUR;
      ST_CUR:  if (div_done) state_next = ST_MOD;
      ST_MOD:  if (div_done) state_next = ST_DIFF;
      ST_DIFF: if (div_done) state_next = ST_TILT;
      ST_TILT: if (div_done) state_next = ST_DONE;
      ST_DONE: if (!out_valid || out_ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    is_div = 1'b0;
    unique case (state)
      ST_NORM, ST_CUR, ST_MOD, ST_DIFF, ST_TILT: is_div = 1'b1;
      default: is_div = 1'b0;
    endcase
    q_pop     = (state == ST_IDLE) && q_valid;
    div_start = is_div && !issued;
    load_out  = (state == ST_DONE) && (!out_valid || out_ready);
  end

  ptf_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quo      (div_quo),
    .rem      (div_rem)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      issued    <= 1'b0;
      pan_t     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (div_start)     issued <= 1'b1;
      else if (div_done) issued <= 1'b0;
      if (state == ST_NORM && div_done) begin
        pan_t <= (job.pan_raw[31] && div_rem != '0) ? TURN_HUND - div_rem : div_rem;
      end
      if (load_out)       out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // job and intermediate results
  always_ff @(posedge clk) begin
    if (q_pop) job <= q_job;
    if (state == ST_MOD && div_done)  diff <= d2[16:0];
    if (state == ST_DIFF && div_done) pan_res <= job.pos + step_off;
    if (state == ST_TILT && div_done) begin
      tilt_res <= (div_quo > DIV_W'(16'hFFFF)) ? 16'hFFFF : div_quo[15:0];
    end
    if (load_out) begin
      out_data.pan_target_steps  <= pan_res;
      out_data.tilt_target_steps <= tilt_res;
      out_data.out_a             <= job.level_a;
      out_data.out_b             <= job.level_b;
      out_data.pulse_out         <= job.pulse;
      out_data.frame_accepted    <= job.accepted;
      out_data.frame_rejected    <= job.rejected;
    end
  end

  // one divide request per step
  a_single_start: assert property (@(posedge clk) disable iff (rst)
    div_start |=> !div_start) else $error("divider started twice");

  // jobs leave the queue only between items
  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> state != ST_IDLE) else $error("job pop did not start work");

  // a waiting result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !load_out) else $error("result overwritten");

endmodule

`default_nettype wire

// ----- rtl/core/pan_tilt_frame_to_step_targets_unit.sv -----
// top level: register port, front, job queue and back
// depends on ptf_pkg, ptf_front, ptf_queue, ptf_back
// results: four runs of the shared divider per transaction, five for the byte that ends
// an accepted frame
// queueing: the back works on one transaction at a time; two more wait in the queue
// reset: synchronous, clears the frame counter, pan target, levels, pulse and queue; tilt target to 3000
`timescale 1ns / 1ps
`default_nettype none

module pan_tilt_frame_to_step_targets_unit import ptf_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire in_item_t    in_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output out_item_t        out_data,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  cfg_t       cfg;
  logic [2:0] reg_idx;
  logic       q_full, q_push, q_pop, q_valid;
  job_t       push_job, head_job;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pan_steps  <= 16'd2400;
      cfg.tilt_steps <= 16'd2600;
      cfg.tilt_min   <= 16'd0;
      cfg.tilt_max   <= 16'd6000;
      cfg.pulse_len  <= 16'd500;
      cfg.end_marker <= 8'hFF;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        REG_PAN_STEPS:  cfg.pan_steps  <= pwdata[15:0];
        REG_TILT_STEPS: cfg.tilt_steps <= pwdata[15:0];
        REG_TILT_MIN:   cfg.tilt_min   <= pwdata[15:0];
        REG_TILT_MAX:   cfg.tilt_max   <= pwdata[15:0];
        REG_PULSE_LEN:  cfg.pulse_len  <= pwdata[15:0];
        REG_END_MARKER: cfg.end_marker <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // register reads
  always_comb begin
    unique case (reg_idx)
      REG_PAN_STEPS:  prdata = {16'b0, cfg.pan_steps};
      REG_TILT_STEPS: prdata = {16'b0, cfg.tilt_steps};
      REG_TILT_MIN:   prdata = {16'b0, cfg.tilt_min};
      REG_TILT_MAX:   prdata = {16'b0, cfg.tilt_max};
      REG_PULSE_LEN:  prdata = {16'b0, cfg.pulse_len};
      REG_END_MARKER: prdata = {24'b0, cfg.end_marker};
      default:        prdata = '0;
    endcase
  end

  ptf_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_job    (push_job)
  );

  ptf_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_job  (push_job),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .head      (head_job)
  );

  ptf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_job     (head_job),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
// testbench for pan_tilt_frame_to_step_targets_unit: frames, ticks and register phases
// depends on ptf_pkg and the unit's rtl; self-checking against a built-in predictor
`timescale 1ns / 1ps

class step_target_board;
  // configuration and state copy
  logic [15:0] pan_steps, tilt_steps, tilt_min, tilt_max, pulse_len;
  logic [7:0]  marker;
  int unsigned byte_idx;
  logic [7:0]  frame_bytes [0:8];
  longint      pan_hund, tilt_hund;
  bit          lvl_a, lvl_b, pulse_on;
  int unsigned pulse_ms;
  ptf_pkg::out_item_t pending [$];
  int mismatches;

  function void reset_state();
    pan_steps = 16'd2400; tilt_steps = 16'd2600; tilt_min = 16'd0; tilt_max = 16'd6000;
    pulse_len = 16'd500; marker = 8'hFF;
    byte_idx = 0; pan_hund = 0; tilt_hund = 3000;
    lvl_a = 0; lvl_b = 0; pulse_on = 0; pulse_ms = 0;
    pending.delete(); mismatches = 0;
  endfunction

  function void write_reg(logic [2:0] idx, logic [31:0] v);
    case (idx)
      ptf_pkg::REG_PAN_STEPS:  pan_steps = v[15:0];
      ptf_pkg::REG_TILT_STEPS: tilt_steps = v[15:0];
      ptf_pkg::REG_TILT_MIN:   tilt_min = v[15:0];
      ptf_pkg::REG_TILT_MAX:   tilt_max = v[15:0];
      ptf_pkg::REG_PULSE_LEN:  pulse_len = v[15:0];
      ptf_pkg::REG_END_MARKER: marker = v[7:0];
      default: ;
    endcase
  endfunction

  // note an accepted input transaction and queue its expected result
  function void note_input(ptf_pkg::in_item_t it);
    ptf_pkg::out_item_t r;
    longint pos, p, t, cur, diff, pan_o, tilt_o, ang;
    bit acc, rej;
    acc = 0; rej = 0;
    if (it.kind == 1'b0) begin
      if (byte_idx < 9) begin
        frame_bytes[byte_idx] = it.rx_byte;
        byte_idx++;
      end else begin
        byte_idx = 0;
        if (it.rx_byte == marker) begin
          acc = 1;
          ang = longint'($signed({frame_bytes[0], frame_bytes[1], frame_bytes[2],
                                  frame_bytes[3]})) % 36000;
          if (ang < 0) ang += 36000;
          pan_hund = ang;
          ang = longint'($signed({frame_bytes[4], frame_bytes[5], frame_bytes[6],
                                  frame_bytes[7]}));
          if (ang < longint'(tilt_min)) ang = tilt_min;
          else if (ang > longint'(tilt_max)) ang = tilt_max;
          tilt_hund = ang;
          lvl_a = frame_bytes[8][ptf_pkg::CTL_A];
          lvl_b = frame_bytes[8][ptf_pkg::CTL_B];
          if (frame_bytes[8][ptf_pkg::CTL_PULSE]) begin
            pulse_on = 1; pulse_ms = 0;
          end
        end else begin
          rej = 1;
        end
      end
    end else if (pulse_ms < 65535) begin
      pulse_ms++;
    end
    if (pulse_on && pulse_ms > pulse_len) pulse_on = 0;
    p = (pan_steps == 0) ? 1 : pan_steps;
    t = (tilt_steps == 0) ? 1 : tilt_steps;
    pos = longint'(it.pan_position);
    cur = ((pos * 36000) / p) % 36000;
    diff = (pan_hund - cur) % 36000;
    if (diff > 18000) diff -= 36000;
    else if (diff < -18000) diff += 36000;
    pan_o = pos + (diff * p) / 36000;
    tilt_o = (tilt_hund * t) / 36000;
    if (tilt_o > 65535) tilt_o = 65535;
    r.pan_target_steps = pan_o[31:0];
    r.tilt_target_steps = tilt_o[15:0];
    r.out_a = lvl_a; r.out_b = lvl_b; r.pulse_out = pulse_on;
    r.frame_accepted = acc; r.frame_rejected = rej;
    pending.push_back(r);
  endfunction

  // compare one result with the oldest expectation
  function void check_result(ptf_pkg::out_item_t got);
    ptf_pkg::out_item_t e;
    if (pending.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result %h", got);
      return;
    end
    e = pending.pop_front();
    if (got.pan_target_steps !== e.pan_target_steps ||
        got.tilt_target_steps !== e.tilt_target_steps ||
        got.out_a !== e.out_a || got.out_b !== e.out_b ||
        got.pulse_out !== e.pulse_out || got.frame_accepted !== e.frame_accepted ||
        got.frame_rejected !== e.frame_rejected) begin
      mismatches++;
      if (mismatches <= 10)
        $display({"mismatch: expected pan %0d tilt %0d a%b b%b p%b acc%b rej%b,",
                  " got pan %0d tilt %0d a%b b%b p%b acc%b rej%b"},
                 e.pan_target_steps, e.tilt_target_steps, e.out_a, e.out_b, e.pulse_out,
                 e.frame_accepted, e.frame_rejected, got.pan_target_steps,
                 got.tilt_target_steps, got.out_a, got.out_b, got.pulse_out,
                 got.frame_accepted, got.frame_rejected);
    end
  endfunction
endclass

module tb;
  import ptf_pkg::*;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0, out_ready = 0;
  in_item_t in_data = '0;
  logic in_ready, out_valid;
  out_item_t out_data;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  step_target_board board;
  int unsigned cycles = 0;
  bit hold_off = 0;

  pan_tilt_frame_to_step_targets_unit dut (.*);

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 3000000) begin
      $display("** pan_tilt_frame_to_step_targets_unit: FAILED **");
      $finish;
    end
  end

  // result side: random stalls, checks on accepted results
  initial begin : sink
    int gap;
    @(posedge clk);
    forever begin
      gap = hold_off ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17));
      if (gap != 0 || hold_off) begin
        out_ready <= 0;
        repeat (gap) @(posedge clk);
        while (hold_off) @(posedge clk);
      end
      out_ready <= 1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      board.check_result(out_data);
    end
  end

  // long receiver stall, counted here
  task automatic long_stall();
    hold_off = 1;
    repeat (1500) @(posedge clk);
    hold_off = 0;
  endtask

  // valid stays up between back-to-back items and drops only before a gap
  task automatic send_item(in_item_t it, bit no_gap);
    int gap;
    gap = (no_gap || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
    if (gap != 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_input(it);
  endtask

  function automatic logic [31:0] rand_pos();
    case ($urandom_range(0, 4))
      0: return 32'h8000_0000 + $urandom_range(0, 3);
      1: return 32'h7FFF_FFFF - $urandom_range(0, 3);
      2: return $urandom_range(0, 20000) - 10000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] rand_angle();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return $urandom;
      3: return $urandom_range(0, 80000) - 40000;
      default: return $urandom_range(0, 36000);
    endcase
  endfunction

  task automatic send_byte(logic [7:0] b, bit no_gap);
    in_item_t it;
    it.kind = 1'b0; it.rx_byte = b; it.pan_position = rand_pos();
    send_item(it, no_gap);
  endtask

  task automatic send_tick(bit no_gap);
    in_item_t it;
    it.kind = 1'b1; it.rx_byte = 8'($urandom); it.pan_position = rand_pos();
    send_item(it, no_gap);
  endtask

  task automatic send_frame(logic [31:0] pan, logic [31:0] tilt, logic [7:0] ctl,
                            logic [7:0] last, bit no_gap);
    for (int i = 0; i < 4; i++) send_byte(pan[31 - 8*i -: 8], no_gap);
    for (int i = 0; i < 4; i++) send_byte(tilt[31 - 8*i -: 8], no_gap);
    send_byte(ctl, no_gap);
    send_byte(last, no_gap);
  endtask

  // apb write: setup then access, then idle with psel low
  task automatic write_reg(logic [2:0] idx, logic [31:0] v);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= v;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    board.write_reg(idx, v);
    psel <= 0; penable <= 0; pwrite <= 0;
    @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  // random phase: mostly well-formed frames mixed with ticks and noise
  task automatic random_phase(int n);
    int sent;
    sent = 0;
    while (sent < n) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: begin
          send_frame(rand_angle(), rand_angle(), 8'($urandom),
                     ($urandom_range(0, 7) == 0) ? 8'($urandom) : board.marker, 0);
          sent += 10;
        end
        5, 6, 7: begin
          repeat ($urandom_range(1, 8)) begin
            send_tick(0); sent++;
          end
        end
        default: begin
          send_byte(8'($urandom), 0); sent++;
        end
      endcase
    end
  endtask

  initial begin : stim
    board = new();
    board.reset_state();
    repeat (12) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: extremes, rejection, pulse start, ticks
    send_frame(32'h7FFF_FFFF, 32'h8000_0000, 8'h07, 8'hFF, 0);
    send_tick(0);
    send_frame(32'h8000_0000, 32'h7FFF_FFFF, 8'h00, 8'h00, 0);
    send_frame(32'd35999, 32'd3000, 8'hF8, 8'hFF, 0);
    send_tick(1);
    drain();

    // crossed limits, short pulse, marker zero
    write_reg(REG_TILT_MIN, 32'd5000);
    write_reg(REG_TILT_MAX, 32'd1000);
    write_reg(REG_PULSE_LEN, 32'd0);
    write_reg(REG_END_MARKER, 32'd0);
    write_reg(REG_PAN_STEPS, 32'd0);
    write_reg(REG_TILT_STEPS, 32'd0);
    send_frame(32'hFFFF_FFFF, 32'd0, 8'h04, 8'h00, 0);
    send_tick(0);
    send_frame(32'd100, 32'd9000, 8'h03, 8'h00, 0);
    drain();
    random_phase(300);
    drain();

    // max sizes and limits, endless pulse; receiver long stall while filling
    write_reg(REG_PAN_STEPS, 32'd65535);
    write_reg(REG_TILT_STEPS, 32'd65535);
    write_reg(REG_TILT_MIN, 32'd0);
    write_reg(REG_TILT_MAX, 32'd65535);
    write_reg(REG_PULSE_LEN, 32'd65535);
    write_reg(REG_END_MARKER, 32'd255);
    fork
      long_stall();
      random_phase(40);
    join
    drain();
    random_phase(300);
    drain();

    // random registers
    repeat (3) begin
      write_reg(REG_PAN_STEPS, $urandom_range(1, 65535));
      write_reg(REG_TILT_STEPS, $urandom_range(1, 65535));
      write_reg(REG_TILT_MIN, $urandom_range(0, 36000));
      write_reg(REG_TILT_MAX, $urandom_range(0, 36000));
      write_reg(REG_PULSE_LEN, $urandom_range(0, 20));
      write_reg(REG_END_MARKER, $urandom_range(0, 255));
      random_phase(250);
      drain();
    end

    if (board.mismatches == 0 && board.pending.size() == 0)
      $display("** pan_tilt_frame_to_step_targets_unit: PASSED **");
    else
      $display("** pan_tilt_frame_to_step_targets_unit: FAILED **");
    $finish;
  end
endmodule
